>>> rtl/jeo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jeo_pkg;

  // Default ring capacity
  localparam int MAX_PEOPLE_DEF = 64;

  // Fixed field width of counts and positions
  localparam int FIELD_W = 7;

  typedef struct packed {
    logic [FIELD_W-1:0] people;
    logic [FIELD_W-1:0] start_pos;
    logic [FIELD_W-1:0] step;
  } jeo_in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] removed_pos;
    logic               last;
  } jeo_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_BUILD,
    ST_LOOP,
    ST_ADV,
    ST_RM
  } jeo_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture a new run
    logic mod_sub;    // reduce start position by people
    logic setup;      // place counter and predecessor
    logic build_wr;   // write one ring link
    logic adv;        // take one link step
    logic rm;         // unlink the current person
    logic emit;       // load the output register
    logic emit_last;  // mark the survivor
  } jeo_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_nonzero;
    logic s_ge_count;
    logic build_end;
    logic rem_one;
    logic k_zero;
    logic out_free;
  } jeo_status_t;

endpackage

`default_nettype wire

>>> rtl/josephus_elimination_order_top.sv
// Sequence: start%people by repeated subtraction, then placement of the counter and
// predecessor, then the ring is built one link per person, then step-1 link steps
// lead to the first removed position.
// A new run is taken only in idle, after the survivor has been emitted; each link
// step passes through ST_LOOP and ST_ADV on the registered link memory read.
// Reset: synchronous, active low; controller returns to idle and the output beat
// is dropped; the link memory is not cleared and is rebuilt by every run.
`timescale 1ns / 1ps
`default_nettype none

module josephus_elimination_order_top
  import jeo_pkg::*;
#(
  parameter int MAX_PEOPLE = MAX_PEOPLE_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire jeo_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output jeo_out_t     out_data
);

  jeo_cmd_t    cmd;
  jeo_status_t status;

  jeo_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  jeo_dp #(
    .MAX_PEOPLE (MAX_PEOPLE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> rtl/jeo_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module jeo_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/jeo_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module jeo_ctrl
  import jeo_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire jeo_status_t status,
  output jeo_cmd_t         cmd
);

  jeo_state_t state_r;
  jeo_state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        // An empty ring is taken and dropped
        if (in_valid && status.in_nonzero) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        if (status.s_ge_count) begin
          cmd.mod_sub = 1'b1;
        end else begin
          cmd.setup = 1'b1;
          state_nxt = ST_BUILD;
        end
      end
      ST_BUILD: begin
        cmd.build_wr = 1'b1;
        if (status.build_end) begin
          state_nxt = ST_LOOP;
        end
      end
      ST_LOOP: begin
        if (status.rem_one) begin
          if (status.out_free) begin
            cmd.emit      = 1'b1;
            cmd.emit_last = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else if (!status.k_zero) begin
          state_nxt = ST_ADV;
        end else if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_RM;
        end
      end
      ST_ADV: begin
        cmd.adv   = 1'b1;
        state_nxt = ST_LOOP;
      end
      ST_RM: begin
        cmd.rm    = 1'b1;
        state_nxt = ST_LOOP;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/jeo_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module jeo_dp
  import jeo_pkg::*;
#(
  parameter int MAX_PEOPLE = MAX_PEOPLE_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire jeo_in_t  in_data,
  input  wire jeo_cmd_t cmd,
  output jeo_status_t   status,
  output logic          out_valid,
  input  wire logic     out_ready,
  output jeo_out_t      out_data
);

  localparam int IW = $clog2(MAX_PEOPLE);
  localparam logic [FIELD_W-1:0] MAX_W = FIELD_W'(MAX_PEOPLE);

  logic [FIELD_W-1:0] count_r;
  logic [FIELD_W-1:0] s_r;
  logic [FIELD_W-1:0] step_r;
  logic [FIELD_W-1:0] k_r;
  logic [FIELD_W-1:0] rem_r;
  logic [IW-1:0]      cur_r;
  logic [IW-1:0]      prev_r;
  logic [IW-1:0]      idx_r;
  logic               out_valid_r;
  jeo_out_t           out_r;

  logic [IW-1:0]      rdata;
  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  logic [IW-1:0]      ram_wdata;
  logic [FIELD_W-1:0] idx_inc;
  logic [IW-1:0]      ring_val;
  logic [FIELD_W-1:0] skip;
  logic [FIELD_W-1:0] prev_init;

  // Ring building and start placement
  always_comb begin
    idx_inc   = FIELD_W'(idx_r) + FIELD_W'(1);
    ring_val  = (idx_inc == count_r) ? '0 : IW'(idx_inc);
    skip      = (s_r == '0) ? (count_r - FIELD_W'(1)) : (s_r - FIELD_W'(1));
    prev_init = (skip == '0) ? (count_r - FIELD_W'(1)) : (skip - FIELD_W'(1));
  end

  // Link memory port selection
  always_comb begin
    ram_we    = cmd.build_wr | cmd.rm;
    ram_waddr = cmd.build_wr ? idx_r : prev_r;
    ram_wdata = cmd.build_wr ? ring_val : rdata;
  end

  jeo_ram #(
    .WIDTH (IW),
    .DEPTH (MAX_PEOPLE)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cur_r),
    .rdata (rdata)
  );

  // Run registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      count_r <= (in_data.people > MAX_W) ? MAX_W : in_data.people;
      s_r     <= in_data.start_pos;
      step_r  <= (in_data.step == '0) ? FIELD_W'(1) : in_data.step;
    end
    if (cmd.mod_sub) begin
      s_r <= s_r - count_r;
    end
    if (cmd.setup) begin
      cur_r  <= IW'(skip);
      prev_r <= IW'(prev_init);
      k_r    <= step_r - FIELD_W'(1);
      rem_r  <= count_r;
      idx_r  <= '0;
    end
    if (cmd.build_wr) begin
      idx_r <= IW'(idx_inc);
    end
    // Advance one link
    if (cmd.adv) begin
      prev_r <= cur_r;
      cur_r  <= rdata;
      k_r    <= k_r - FIELD_W'(1);
    end
    // Drop the current person and restart the count
    if (cmd.rm) begin
      cur_r <= rdata;
      rem_r <= rem_r - FIELD_W'(1);
      k_r   <= step_r - FIELD_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.removed_pos <= FIELD_W'(cur_r) + FIELD_W'(1);
      out_r.last        <= cmd.emit_last;
    end
  end

  // Status back to the controller
  always_comb begin
    status.in_nonzero = (in_data.people != '0);
    status.s_ge_count = (s_r >= count_r);
    status.build_end  = (idx_inc == count_r);
    status.rem_one    = (rem_r == FIELD_W'(1));
    status.k_zero     = (k_r == '0);
    status.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire
